// ===== rtl/core/capacitive_touch_key_detector_core_assert.svh =====
// Assertion helpers used by the checker file.
// Guard macro for this header.
`ifndef CAPACITIVE_TOUCH_KEY_DETECTOR_CORE_ASSERT_SVH
`define CAPACITIVE_TOUCH_KEY_DETECTOR_CORE_ASSERT_SVH

// Same-edge implication.
`define CTKD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-edge implication.
`define CTKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ctkd_pkg.sv =====
package ctkd_pkg;

   localparam int SampleW  = 16;
   localparam int FracW    = 16;
   localparam int AvgW     = SampleW + FracW;
   localparam int ThrW     = 16;
   localparam int AlphaW   = 17;
   localparam int KeyW     = 5;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 17;

   localparam logic [AlphaW-1:0] AlphaOne = AlphaW'(65536);

   localparam logic [ThrW-1:0]   ThresholdReset = ThrW'(50);
   localparam logic [ThrW-1:0]   DeadZoneReset  = ThrW'(20);
   localparam logic [AlphaW-1:0] AlphaReset     = AlphaW'(6554);

   typedef enum logic [1:0] {
      OP_UPDATE    = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_CLEAR     = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_RELEASED = 2'd0,
      ST_SINGLE   = 2'd1,
      ST_DOUBLE   = 2'd2
   } key_state_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_DEAD_ZONE = 2'd1,
      CSR_ALPHA     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SampleW-1:0] baseline;
      logic [AvgW-1:0]    average;
      key_state_type      state;
   } key_entry_type;

endpackage

// ===== rtl/core/capacitive_touch_key_detector_core.sv =====
// Per-key capacitive touch qualifier with baseline and moving average.
// Request channel (req_valid/req_stall): opcode, key index and raw sample.
// Each accepted request beat yields exactly one response beat (rsp_valid/rsp_stall)
// with the key's touch state and the integer part of its average after the step.
// Config writes (csr_valid/csr_ready, csr_ready always high) set the threshold,
// dead zone and smoothing weight; write them only while the block is idle.
// Requests are registered in the compute stage, then in the response register.
// Throughput: one request per cycle unless stalled, also for same-key repeats;
// the key table is one RAM (registered read) and the previous write is bypassed.
// The single 18x33 multiply of the average update sets the critical path.
// Reset restores the default config and clears a valid bit per key, so every
// key reads as released with zero baseline and average; no clearing pass.
// A stalled response holds; req_stall rises only when the compute stage is full
// and the response register is stalled, so one beat can sit in each stage.
// Keys at or above NUM_KEYS change nothing and answer released / zero.
module capacitive_touch_key_detector_core #(
   parameter int NUM_KEYS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [ctkd_pkg::KeyW-1:0]           req_key_index,
   input  logic [ctkd_pkg::SampleW-1:0]        req_raw_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_key_state,
   output logic [ctkd_pkg::SampleW-1:0]        rsp_average_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ctkd_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [ctkd_pkg::CsrDataW-1:0]       csr_wdata
);

   localparam int AddrW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int EntryW = $bits(ctkd_pkg::key_entry_type);

   // config
   logic [ctkd_pkg::ThrW-1:0]   threshold_ff, threshold_in;
   logic [ctkd_pkg::ThrW-1:0]   dead_zone_ff, dead_zone_in;
   logic [ctkd_pkg::AlphaW-1:0] alpha_ff, alpha_in;

   // compute stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [1:0]                    s1_op_ff;
   logic [AddrW-1:0]              s1_addr_ff;
   logic [ctkd_pkg::SampleW-1:0]  s1_sample_ff;
   logic                          s1_in_range_ff;
   logic                          byp_ff, byp_in;
   ctkd_pkg::key_entry_type       last_wr_ff;
   logic [NUM_KEYS-1:0]           entry_valid_ff, entry_valid_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   ctkd_pkg::key_state_type       rsp_state_ff;
   logic [ctkd_pkg::SampleW-1:0]  rsp_level_ff;

   logic                          accept;
   logic                          s1_go;
   logic                          wr_en;
   logic [8:0]                    key_wide;
   logic                          key_in_range;
   logic [AddrW-1:0]              rd_addr;
   logic [EntryW-1:0]             rd_data;
   ctkd_pkg::key_entry_type       ram_entry;
   ctkd_pkg::key_entry_type       cur;
   ctkd_pkg::key_entry_type       nxt;

   logic [ctkd_pkg::AlphaW-1:0]   alpha_eff;
   logic [ctkd_pkg::AvgW-1:0]     s_fx;
   logic signed [ctkd_pkg::AvgW:0]     diff;
   logic signed [ctkd_pkg::AvgW+18:0]  prod;
   logic signed [ctkd_pkg::AvgW+1:0]   step;
   logic signed [ctkd_pkg::AvgW+1:0]   ema_wide;
   logic [ctkd_pkg::AvgW-1:0]     ema;
   logic signed [ctkd_pkg::SampleW+1:0] rise;
   logic                          in_dead_zone;
   logic [ctkd_pkg::AvgW:0]       touch_limit;
   logic                          touched;

   assign csr_ready = 1'b1;

   assign s1_go     = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = s1_go && s1_in_range_ff;

   assign key_wide     = {4'b0000, req_key_index};
   assign key_in_range = key_wide < 9'(NUM_KEYS);
   assign rd_addr      = key_wide[AddrW-1:0];

   ctkd_ram #(
      .WIDTH (EntryW),
      .DEPTH (NUM_KEYS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ram_entry = rd_data;

   // previous write bypasses the RAM; entries never written read as reset
   always_comb begin
      if (byp_ff) begin
         cur = last_wr_ff;
      end else if (entry_valid_ff[s1_addr_ff]) begin
         cur = ram_entry;
      end else begin
         cur = '0;
      end
   end

   // average update: avg + floor(alpha * (S - avg) / 2^16)
   assign alpha_eff = (alpha_ff > ctkd_pkg::AlphaOne) ? ctkd_pkg::AlphaOne : alpha_ff;
   assign s_fx      = {s1_sample_ff, {ctkd_pkg::FracW{1'b0}}};
   assign diff      = $signed({1'b0, s_fx}) - $signed({1'b0, cur.average});
   assign prod      = $signed({1'b0, alpha_eff}) * diff;
   assign step      = prod[ctkd_pkg::AvgW+17:ctkd_pkg::FracW];
   assign ema_wide  = $signed({2'b00, cur.average}) + step;
   assign ema       = ema_wide[ctkd_pkg::AvgW-1:0];

   assign rise = $signed({2'b00, s1_sample_ff}) - $signed({2'b00, cur.baseline});
   assign in_dead_zone = rise < $signed({2'b00, dead_zone_ff});
   assign touch_limit  = {1'b0, cur.average}
                       + {1'b0, threshold_ff, {ctkd_pkg::FracW{1'b0}}};
   assign touched      = {1'b0, s_fx} > touch_limit;

   always_comb begin
      nxt = cur;
      case (s1_op_ff)
         ctkd_pkg::OP_CLEAR: begin
            nxt = '0;
         end
         ctkd_pkg::OP_CALIBRATE: begin
            if (s1_sample_ff > cur.baseline) begin
               nxt.baseline = s1_sample_ff;
            end
            nxt.average = {nxt.baseline, {ctkd_pkg::FracW{1'b0}}};
            nxt.state   = ctkd_pkg::ST_RELEASED;
         end
         ctkd_pkg::OP_UPDATE: begin
            if (in_dead_zone) begin
               // a touched key snaps back to its baseline on release
               if (cur.state != ctkd_pkg::ST_RELEASED) begin
                  nxt.average = {cur.baseline, {ctkd_pkg::FracW{1'b0}}};
               end else begin
                  nxt.average = ema;
               end
               nxt.state = ctkd_pkg::ST_RELEASED;
            end else if (touched) begin
               nxt.average = s_fx;
               nxt.state   = (cur.state == ctkd_pkg::ST_RELEASED) ?
                             ctkd_pkg::ST_SINGLE : ctkd_pkg::ST_DOUBLE;
            end else begin
               nxt.average = ema;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_comb begin
      threshold_in = threshold_ff;
      dead_zone_in = dead_zone_ff;
      alpha_in     = alpha_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ctkd_pkg::CSR_THRESHOLD: threshold_in = csr_wdata[ctkd_pkg::ThrW-1:0];
            ctkd_pkg::CSR_DEAD_ZONE: dead_zone_in = csr_wdata[ctkd_pkg::ThrW-1:0];
            ctkd_pkg::CSR_ALPHA:     alpha_in     = csr_wdata[ctkd_pkg::AlphaW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      // the beat in the compute stage writes this key at the same edge
      byp_in      = s1_valid_ff && s1_in_range_ff && (s1_addr_ff == rd_addr);
      rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);
      entry_valid_in = entry_valid_ff;
      if (wr_en) begin
         entry_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= ctkd_pkg::ThresholdReset;
         dead_zone_ff   <= ctkd_pkg::DeadZoneReset;
         alpha_ff       <= ctkd_pkg::AlphaReset;
         s1_valid_ff    <= 1'b0;
         byp_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         threshold_ff   <= threshold_in;
         dead_zone_ff   <= dead_zone_in;
         alpha_ff       <= alpha_in;
         s1_valid_ff    <= s1_valid_in;
         if (accept) begin
            byp_ff <= byp_in;
         end
         rsp_valid_ff   <= rsp_valid_in;
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_opcode;
         s1_addr_ff     <= rd_addr;
         s1_sample_ff   <= req_raw_sample;
         s1_in_range_ff <= key_in_range;
      end
      if (wr_en) begin
         last_wr_ff <= nxt;
      end
      if (s1_go) begin
         if (s1_in_range_ff) begin
            rsp_state_ff <= nxt.state;
            rsp_level_ff <= nxt.average[ctkd_pkg::AvgW-1:ctkd_pkg::FracW];
         end else begin
            rsp_state_ff <= ctkd_pkg::ST_RELEASED;
            rsp_level_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_key_state     = rsp_state_ff;
   assign rsp_average_level = rsp_level_ff;

endmodule

// ===== rtl/core/ctkd_ram.sv =====
module ctkd_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ctkd_checker.sv =====
`include "capacitive_touch_key_detector_core_assert.svh"

module ctkd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [1:0]                      req_opcode,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [1:0]                      rsp_key_state,
   input logic [ctkd_pkg::SampleW-1:0]    rsp_average_level
);

   // a stalled response beat holds
   `CTKD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_state) && $stable(rsp_average_level), "stalled response changed")

   // input backpressure only comes from a stalled, full response register
   `CTKD_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without response stall")

   // a cleared key's response reports released with a zero average
   `CTKD_ASSERT_NEXT(a_clear_result, clock, reset, (req_valid && !req_stall && req_opcode == ctkd_pkg::OP_CLEAR) ##1 !(rsp_valid && rsp_stall), rsp_valid && rsp_key_state == ctkd_pkg::ST_RELEASED && rsp_average_level == '0, "clear result wrong")

   // calibration always leaves the key released
   `CTKD_ASSERT_NEXT(a_cal_result, clock, reset, (req_valid && !req_stall && req_opcode == ctkd_pkg::OP_CALIBRATE) ##1 !(rsp_valid && rsp_stall), rsp_valid && rsp_key_state == ctkd_pkg::ST_RELEASED, "calibration result not released")

endmodule

bind capacitive_touch_key_detector_core ctkd_checker u_ctkd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_key_state     (rsp_key_state),
   .rsp_average_level (rsp_average_level)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int KeyCount   = 32;
   localparam int StuckLimit = 5000;
   localparam int PhaseItems = 150;
   localparam logic [1:0] OpUnused = 2'd3;

   typedef struct packed {
      logic [1:0]                   op;
      logic [ctkd_pkg::KeyW-1:0]    key;
      logic [ctkd_pkg::SampleW-1:0] smp;
   } scan_item_type;

   typedef struct packed {
      ctkd_pkg::key_state_type      state;
      logic [ctkd_pkg::SampleW-1:0] level;
   } touch_report_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_opcode = '0;
   logic [ctkd_pkg::KeyW-1:0]     req_key_index = '0;
   logic [ctkd_pkg::SampleW-1:0]  req_raw_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_key_state;
   logic [ctkd_pkg::SampleW-1:0]  rsp_average_level;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ctkd_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [ctkd_pkg::CsrDataW-1:0] csr_wdata = '0;

   // shadow of the key table and config
   logic [ctkd_pkg::SampleW-1:0] base_tab [KeyCount];
   logic [ctkd_pkg::AvgW-1:0]    avg_tab [KeyCount];
   ctkd_pkg::key_state_type      st_tab [KeyCount];
   logic [ctkd_pkg::ThrW-1:0]    thr_cfg = ctkd_pkg::ThresholdReset;
   logic [ctkd_pkg::ThrW-1:0]    dz_cfg = ctkd_pkg::DeadZoneReset;
   logic [ctkd_pkg::AlphaW-1:0]  alpha_cfg = ctkd_pkg::AlphaReset;

   scan_item_type    scan_queue [$];
   touch_report_type report_queue [$];
   int               items_queued = 0;
   int               reports_checked = 0;
   int               fail_count = 0;
   int               send_gap = 0;
   int               stall_gap = 0;
   int               stuck_cycles = 0;
   bit               calm = 1'b0;

   capacitive_touch_key_detector_core #(
      .NUM_KEYS(KeyCount)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key_index(req_key_index),
      .req_raw_sample(req_raw_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_key_state(rsp_key_state),
      .rsp_average_level(rsp_average_level),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one beat to the key table shadow and returns the report it yields.
   function automatic touch_report_type advance_key(logic [1:0] op,
                                                    logic [ctkd_pkg::KeyW-1:0] key,
                                                    logic [ctkd_pkg::SampleW-1:0] smp);
      logic [63:0]      a;
      logic [63:0]      s_fx;
      logic [63:0]      avg;
      logic [63:0]      ema;
      int               rise;
      touch_report_type rep;
      a = (alpha_cfg > ctkd_pkg::AlphaOne) ? 64'(ctkd_pkg::AlphaOne) : 64'(alpha_cfg);
      s_fx = 64'(smp) << ctkd_pkg::FracW;
      avg = 64'(avg_tab[key]);
      ema = (a * s_fx + (64'(ctkd_pkg::AlphaOne) - a) * avg) >> 16;
      rise = int'(smp) - int'(base_tab[key]);
      case (op)
         ctkd_pkg::OP_CLEAR: begin
            base_tab[key] = '0;
            avg_tab[key] = '0;
            st_tab[key] = ctkd_pkg::ST_RELEASED;
         end
         ctkd_pkg::OP_CALIBRATE: begin
            if (smp > base_tab[key])
               base_tab[key] = smp;
            avg_tab[key] = ctkd_pkg::AvgW'(base_tab[key]) << ctkd_pkg::FracW;
            st_tab[key] = ctkd_pkg::ST_RELEASED;
         end
         ctkd_pkg::OP_UPDATE: begin
            if (rise < int'(dz_cfg)) begin
               if (st_tab[key] != ctkd_pkg::ST_RELEASED)
                  avg_tab[key] = ctkd_pkg::AvgW'(base_tab[key]) << ctkd_pkg::FracW;
               else
                  avg_tab[key] = ctkd_pkg::AvgW'(ema);
               st_tab[key] = ctkd_pkg::ST_RELEASED;
            end else if (s_fx > avg + (64'(thr_cfg) << ctkd_pkg::FracW)) begin
               avg_tab[key] = ctkd_pkg::AvgW'(s_fx);
               st_tab[key] = (st_tab[key] == ctkd_pkg::ST_RELEASED) ?
                             ctkd_pkg::ST_SINGLE : ctkd_pkg::ST_DOUBLE;
            end else begin
               avg_tab[key] = ctkd_pkg::AvgW'(ema);
            end
         end
         default: ;
      endcase
      rep.state = st_tab[key];
      rep.level = avg_tab[key][ctkd_pkg::AvgW-1:ctkd_pkg::FracW];
      return rep;
   endfunction

   task automatic queue_item(logic [1:0] op, logic [ctkd_pkg::KeyW-1:0] key, int lvl);
      scan_item_type it;
      it.op = op;
      it.key = key;
      it.smp = (lvl < 0) ? '0 : (lvl > 65535) ? '1 : ctkd_pkg::SampleW'(lvl);
      scan_queue.push_back(it);
      items_queued++;
   endtask

   // Usually calibrate a key, then a run of updates around its baseline, at times a clear.
   task automatic queue_session();
      logic [ctkd_pkg::KeyW-1:0] key;
      int                        base;
      int                        lvl;
      int                        n;
      key = ($urandom_range(0, 3) == 0) ? ctkd_pkg::KeyW'($urandom_range(0, 31))
                                        : ctkd_pkg::KeyW'($urandom_range(0, 5));
      base = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(0, 60000));
      if ($urandom_range(0, 4) != 0) begin
         queue_item(ctkd_pkg::OP_CALIBRATE, key, base - int'($urandom_range(0, 40)));
         queue_item(ctkd_pkg::OP_CALIBRATE, key, base);
      end
      n = $urandom_range(3, 12);
      repeat (n) begin
         case ($urandom_range(0, 9)) inside
            [0:1]: lvl = base - int'($urandom_range(0, 300));
            [2:4]: lvl = base + int'($urandom_range(0, dz_cfg));
            [5:7]: lvl = base + int'(dz_cfg) + int'($urandom_range(0, thr_cfg));
            default: lvl = base + int'(dz_cfg) + int'(thr_cfg)
                           + int'($urandom_range(1, 3000));
         endcase
         queue_item(ctkd_pkg::OP_UPDATE, key, lvl);
      end
      if ($urandom_range(0, 5) == 0)
         queue_item(ctkd_pkg::OP_CLEAR, key, int'($urandom_range(0, 65535)));
   endtask

   task automatic queue_random(int count);
      int goal;
      goal = items_queued + count;
      while (items_queued < goal) begin
         if ($urandom_range(0, 6) == 0)
            queue_item(2'($urandom_range(0, 3)), ctkd_pkg::KeyW'($urandom_range(0, 31)),
                       int'($urandom_range(0, 65535)));
         else
            queue_session();
      end
   endtask

   task automatic write_reg(ctkd_pkg::csr_index_type idx,
                            logic [ctkd_pkg::CsrDataW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ctkd_pkg::CSR_THRESHOLD: thr_cfg = val[ctkd_pkg::ThrW-1:0];
         ctkd_pkg::CSR_DEAD_ZONE: dz_cfg = val[ctkd_pkg::ThrW-1:0];
         ctkd_pkg::CSR_ALPHA:     alpha_cfg = val[ctkd_pkg::AlphaW-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(logic [ctkd_pkg::ThrW-1:0] thr, logic [ctkd_pkg::ThrW-1:0] dz,
                               logic [ctkd_pkg::AlphaW-1:0] alpha);
      write_reg(ctkd_pkg::CSR_THRESHOLD, ctkd_pkg::CsrDataW'(thr));
      write_reg(ctkd_pkg::CSR_DEAD_ZONE, ctkd_pkg::CsrDataW'(dz));
      write_reg(ctkd_pkg::CSR_ALPHA, ctkd_pkg::CsrDataW'(alpha));
      csr_valid <= 1'b0;
   endtask

   // sender holds off until every report of the queued beats is in
   task automatic wait_drained();
      do @(posedge clock); while (reports_checked != items_queued);
   endtask

   initial begin
      for (int k = 0; k < KeyCount; k++) begin
         base_tab[k] = '0;
         avg_tab[k] = '0;
         st_tab[k] = ctkd_pkg::ST_RELEASED;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_item(ctkd_pkg::OP_UPDATE, 0, 0);
      queue_item(OpUnused, 0, 65535);
      queue_item(ctkd_pkg::OP_CALIBRATE, 1, 1000);
      queue_item(ctkd_pkg::OP_CALIBRATE, 1, 500);
      queue_item(ctkd_pkg::OP_UPDATE, 1, 900);
      queue_item(ctkd_pkg::OP_UPDATE, 1, 1100);
      queue_item(ctkd_pkg::OP_UPDATE, 1, 1300);
      queue_item(ctkd_pkg::OP_UPDATE, 1, 1300);
      queue_item(ctkd_pkg::OP_UPDATE, 1, 1005);
      queue_item(OpUnused, 1, 0);
      queue_item(ctkd_pkg::OP_CLEAR, 1, 12345);
      queue_item(ctkd_pkg::OP_CALIBRATE, 31, 65535);
      queue_item(ctkd_pkg::OP_UPDATE, 31, 65535);
      queue_item(ctkd_pkg::OP_UPDATE, 30, 65535);
      queue_item(ctkd_pkg::OP_UPDATE, 30, 65535);
      queue_item(ctkd_pkg::OP_UPDATE, 30, 0);
      queue_item(ctkd_pkg::OP_UPDATE, 21, 16'h5555);
      queue_item(ctkd_pkg::OP_UPDATE, 10, 16'hAAAA);
      queue_item(ctkd_pkg::OP_CALIBRATE, 21, 16'hAAAA);
      queue_item(ctkd_pkg::OP_CLEAR, 31, 0);
      queue_item(ctkd_pkg::OP_CLEAR, 30, 65535);
      queue_item(OpUnused, 31, 0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_config(0, 0, 0);
            1: write_config(16'hFFFF, 16'hFFFF, ctkd_pkg::AlphaOne);
            2: write_config(10, 5, 17'h1FFFF);
            3: write_config(200, 0, 1);
            4: write_config(16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)),
                            17'($urandom_range(65537, 131071)));
            default: write_config(16'($urandom_range(0, 400)), 16'($urandom_range(0, 150)),
                                  17'($urandom_range(0, 65536)));
         endcase
         queue_random(PhaseItems);
         wait_drained();
      end

      calm = 1'b1;
      write_config(ctkd_pkg::ThresholdReset, ctkd_pkg::DeadZoneReset, ctkd_pkg::AlphaReset);
      queue_random(PhaseItems);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // request driver: payload only moves when the slot is empty or the beat is taken
   always @(posedge clock) begin
      scan_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            report_queue.push_back(advance_key(req_opcode, req_key_index, req_raw_sample));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (scan_queue.size() != 0) begin
            if (!calm && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else begin
               it = scan_queue.pop_front();
               req_opcode <= it.op;
               req_key_index <= it.key;
               req_raw_sample <= it.smp;
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      touch_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (report_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, got state %0d level %0d",
                        $time, rsp_key_state, rsp_average_level);
            end else begin
               want = report_queue.pop_front();
               reports_checked++;
               if (rsp_key_state !== want.state) begin
                  fail_count++;
                  $display("%0t: key_state mismatch, expected %0d, got %0d",
                           $time, want.state, rsp_key_state);
               end
               if (rsp_average_level !== want.level) begin
                  fail_count++;
                  $display("%0t: average_level mismatch, expected %0d, got %0d",
                           $time, want.level, rsp_average_level);
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_gap = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
